@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/gslm_pkg.sv @@
package gslm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int TALLY_W    = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_FRAME_SAMPLES_DEF = 512;

  // Serial multiply/divide unit widths
  localparam int MD_ACC_W = 48;
  localparam int MD_SH_W  = 32;
  localparam int MD_DIV_W = 33;
  localparam int MD_CNT_W = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_NUM     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DEN     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN_NUM = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN_DEN = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT        = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_THRESH   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESH  = 4'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST        = 16'd1;
  localparam logic [LEVEL_W-1:0] KNEE_RST        = 15'd24000;
  localparam logic [LEVEL_W-1:0] LIMIT_RST       = 15'd30000;
  localparam logic [LEVEL_W-1:0] AVG_THRESH_RST  = 15'd600;
  localparam logic [LEVEL_W-1:0] PEAK_THRESH_RST = 15'd1200;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    md_op_t                op;
    logic [MD_ACC_W-1:0]   a;
    logic [MD_SH_W-1:0]    b;
    logic [MD_DIV_W-1:0]   v;
    logic [MD_CNT_W-1:0]   n;
  } md_req_t;

  typedef struct packed {
    logic               acc;
    logic               close;
    logic               hit;
    logic               aud;
    logic [LEVEL_W-1:0] mag;
  } meter_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       frame_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       sample_kept;
    logic                       stats_valid;
    logic [LEVEL_W-1:0]         average_level;
    logic [LEVEL_W-1:0]         peak_level;
    logic                       audible;
    logic [TALLY_W-1:0]         limited_samples;
    logic                       audible_ever;
  } out_word_t;

endpackage

@@ rtl/core/gslm_muldiv.sv @@
module gslm_muldiv (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  gslm_pkg::md_req_t                 req,
  output logic                              busy,
  output logic                              done,
  output logic [gslm_pkg::MD_ACC_W-1:0]     result
);
  import gslm_pkg::*;

  md_op_t              op;
  logic [MD_ACC_W-1:0] acc;
  logic [MD_ACC_W-1:0] opnd;
  logic [MD_SH_W-1:0]  sh;
  logic [MD_CNT_W-1:0] cnt;
  logic [MD_DIV_W:0]   rem_sh;
  logic [MD_DIV_W:0]   rem_diff;
  logic                rem_ge;

  // Restoring divide step: shift in the next dividend bit, trial subtract.
  always_comb begin
    rem_sh   = {acc[MD_DIV_W-1:0], sh[MD_SH_W-1]};
    rem_diff = rem_sh - {1'b0, opnd[MD_DIV_W-1:0]};
    rem_ge   = (rem_sh >= {1'b0, opnd[MD_DIV_W-1:0]});
  end

  assign result = (op == MD_MUL) ? acc : MD_ACC_W'(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == MD_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op  <= req.op;
      cnt <= req.n;
      sh  <= req.b;
      if (req.op == MD_MUL) begin
        acc  <= '0;
        opnd <= req.a;
      end else begin
        acc  <= req.a;
        opnd <= MD_ACC_W'(req.v);
      end
    end else if (busy) begin
      cnt <= cnt - MD_CNT_W'(1);
      if (op == MD_MUL) begin
        if (sh[0]) begin
          acc <= acc + opnd;
        end
        opnd <= {opnd[MD_ACC_W-2:0], 1'b0};
        sh   <= {1'b0, sh[MD_SH_W-1:1]};
      end else begin
        if (rem_ge) begin
          acc <= MD_ACC_W'(rem_diff[MD_DIV_W-1:0]);
        end else begin
          acc <= MD_ACC_W'(rem_sh[MD_DIV_W-1:0]);
        end
        sh <= {sh[MD_SH_W-2:0], rem_ge};
      end
    end
  end

endmodule

@@ rtl/core/gslm_meter.sv @@
module gslm_meter #(
  parameter  int MAX_FRAME_SAMPLES = gslm_pkg::MAX_FRAME_SAMPLES_DEF,
  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1),
  localparam int SUM_W = gslm_pkg::LEVEL_W + CNT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gslm_pkg::meter_ctl_t          ctl,
  output logic [SUM_W-1:0]              sum,
  output logic [gslm_pkg::LEVEL_W-1:0]  peak,
  output logic [CNT_W-1:0]              count,
  output logic [CNT_W-1:0]              tally,
  output logic                          seen,
  output logic                          full
);
  import gslm_pkg::*;

  assign full = (count >= CNT_W'(MAX_FRAME_SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      peak  <= '0;
      count <= '0;
      tally <= '0;
      seen  <= 1'b0;
    end else if (ctl.close) begin
      sum   <= '0;
      peak  <= '0;
      count <= '0;
      tally <= '0;
      if (ctl.aud) begin
        seen <= 1'b1;
      end
    end else if (ctl.acc) begin
      sum   <= sum + SUM_W'(ctl.mag);
      count <= count + CNT_W'(1);
      if (ctl.mag > peak) begin
        peak <= ctl.mag;
      end
      if (ctl.hit) begin
        tally <= tally + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/gain_soft_limiter_level_meter.sv @@
// A word above the knee takes longer than one below it; a frame-end word adds the
// average and report steps, the first word after a gain register write adds the cap
// recompute, and a word past the frame cap skips the gain and limiter steps.
// A new word is taken only once the last one is loaded for output; one shared bit-serial
// multiply/divide unit does all the arithmetic. Reset (rst, synchronous): registers to
// their defaults, meter cleared, output empty; the block takes words in the next cycle.
`include "assert_macros.svh"

module gain_soft_limiter_level_meter #(
  parameter int MAX_FRAME_SAMPLES = gslm_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // sample input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gslm_pkg::in_word_t                 in_data,
  // result output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output gslm_pkg::out_word_t                out_data,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gslm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gslm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gslm_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = LEVEL_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAP1,
    S_CAP2,
    S_SC_MUL,
    S_SC_DIV,
    S_LIM_MUL,
    S_LIM_DIV,
    S_UPDATE,
    S_AVG,
    S_REPORT,
    S_EMIT
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are taken whenever out of reset; unknown
  // indexes drop. A write to any gain register marks the capped ratio stale,
  // so the next kept sample recomputes it before scaling.
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]  ratio_num;
  logic [GAIN_W-1:0]  ratio_den;
  logic [GAIN_W-1:0]  max_num;
  logic [GAIN_W-1:0]  max_den;
  logic [LEVEL_W-1:0] knee;
  logic [LEVEL_W-1:0] out_limit;
  logic [LEVEL_W-1:0] avg_thresh;
  logic [LEVEL_W-1:0] peak_thresh;
  logic               cap_stale;
  logic               cap_clear;
  logic               cfg_write;

  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_num   <= GAIN_RST;
      ratio_den   <= GAIN_RST;
      max_num     <= GAIN_RST;
      max_den     <= GAIN_RST;
      knee        <= KNEE_RST;
      out_limit   <= LIMIT_RST;
      avg_thresh  <= AVG_THRESH_RST;
      peak_thresh <= PEAK_THRESH_RST;
      cap_stale   <= 1'b1;
    end else begin
      if (cap_clear) begin
        cap_stale <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN_NUM: begin
            ratio_num <= cfg_data;
            cap_stale <= 1'b1;
          end
          REG_GAIN_DEN: begin
            ratio_den <= cfg_data;
            cap_stale <= 1'b1;
          end
          REG_MAX_GAIN_NUM: begin
            max_num   <= cfg_data;
            cap_stale <= 1'b1;
          end
          REG_MAX_GAIN_DEN: begin
            max_den   <= cfg_data;
            cap_stale <= 1'b1;
          end
          REG_KNEE:        knee        <= cfg_data[LEVEL_W-1:0];
          REG_LIMIT:       out_limit   <= cfg_data[LEVEL_W-1:0];
          REG_AVG_THRESH:  avg_thresh  <= cfg_data[LEVEL_W-1:0];
          REG_PEAK_THRESH: peak_thresh <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Zero denominators count as one.
  logic [GAIN_W-1:0] den_eff;
  logic [GAIN_W-1:0] mden_eff;
  assign den_eff  = (ratio_den == '0) ? GAIN_W'(1) : ratio_den;
  assign mden_eff = (max_den == '0) ? GAIN_W'(1) : max_den;

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  state_t               state;
  logic                 issued;      // current step's operation already started
  logic                 neg;
  logic [SAMPLE_W:0]    in_mag;      // holds 32768 for the most negative sample
  logic                 frame_end_r;
  logic                 kept;
  logic [LEVEL_W-1:0]   mag_r;
  logic                 hit_r;
  logic [MD_ACC_W-1:0]  work;        // product, then limiter overshoot / product
  logic [MD_DIV_W-1:0]  dvs;         // limiter divisor: overshoot + range
  logic [2*GAIN_W-1:0]  p1;          // num * max_den for the cap compare
  logic [GAIN_W-1:0]    gnum;        // capped gain ratio
  logic [GAIN_W-1:0]    gden;
  logic [LEVEL_W-1:0]   avg_r;
  logic [LEVEL_W-1:0]   rep_peak;
  logic [CNT_W-1:0]     rep_tally;
  logic                 rep_aud;

  // Shared serial unit
  logic                 md_start;
  md_req_t              md_req;
  logic                 md_busy;
  logic                 md_done;
  logic [MD_ACC_W-1:0]  md_result;

  // Meter
  meter_ctl_t           mctl;
  logic [SUM_W-1:0]     m_sum;
  logic [LEVEL_W-1:0]   m_peak;
  logic [CNT_W-1:0]     m_count;
  logic [CNT_W-1:0]     m_tally;
  logic                 m_seen;
  logic                 m_full;

  logic [SAMPLE_W:0]    in_ext;
  logic [SAMPLE_W:0]    in_mag_c;
  logic [MD_SH_W-1:0]   scaled;
  logic [LEVEL_W-1:0]   knee_range;
  logic                 aud_now;

  assign in_stall = rst || (state != S_IDLE);

  // Magnitude of the incoming sample; sign is restored on the way out.
  assign in_ext   = {in_data.in_sample[SAMPLE_W-1], in_data.in_sample};
  assign in_mag_c = in_data.in_sample[SAMPLE_W-1] ? ((SAMPLE_W + 1)'(0) - in_ext) : in_ext;

  assign scaled     = md_result[MD_SH_W-1:0];
  assign knee_range = out_limit - knee;
  assign aud_now    = (avg_r >= avg_thresh) || (m_peak >= peak_thresh);
  assign cap_clear  = (state == S_CAP2) && md_done;

  // ---------------------------------------------------------------------------
  // Operation requests for the shared unit. Each compute step issues one
  // operation in its first cycle and moves on when the unit reports done.
  // ---------------------------------------------------------------------------
  always_comb begin
    md_req    = '{op: MD_MUL, a: '0, b: '0, v: '0, n: '0};
    md_start  = 1'b0;
    case (state)
      S_CAP1: begin
        // num * max_den
        md_req.a = MD_ACC_W'(ratio_num);
        md_req.b = MD_SH_W'(mden_eff);
        md_req.n = MD_CNT_W'(GAIN_W);
        md_start = !issued;
      end
      S_CAP2: begin
        // max_num * den
        md_req.a = MD_ACC_W'(max_num);
        md_req.b = MD_SH_W'(den_eff);
        md_req.n = MD_CNT_W'(GAIN_W);
        md_start = !issued;
      end
      S_SC_MUL: begin
        md_req.a = MD_ACC_W'(in_mag);
        md_req.b = MD_SH_W'(gnum);
        md_req.n = MD_CNT_W'(GAIN_W);
        md_start = !issued;
      end
      S_SC_DIV: begin
        // full 32-bit quotient, remainder starts at zero
        md_req.op = MD_DIV;
        md_req.b  = work[MD_SH_W-1:0];
        md_req.v  = MD_DIV_W'(gden);
        md_req.n  = MD_CNT_W'(MD_SH_W);
        md_start  = !issued;
      end
      S_LIM_MUL: begin
        // overshoot * range
        md_req.a = MD_ACC_W'(work[MD_SH_W-1:0]);
        md_req.b = MD_SH_W'(knee_range);
        md_req.n = MD_CNT_W'(LEVEL_W);
        md_start = !issued;
      end
      S_LIM_DIV: begin
        // Quotient is below range, so only the low LEVEL_W bits are worked:
        // preload the remainder with the upper dividend bits.
        md_req.op = MD_DIV;
        md_req.a  = MD_ACC_W'(work[MD_ACC_W-1:LEVEL_W]);
        md_req.b  = {work[LEVEL_W-1:0], {(MD_SH_W - LEVEL_W){1'b0}}};
        md_req.v  = dvs;
        md_req.n  = MD_CNT_W'(LEVEL_W);
        md_start  = !issued;
      end
      S_AVG: begin
        // Mean of 15-bit magnitudes fits in 15 bits: same preload trick.
        md_req.op = MD_DIV;
        md_req.a  = MD_ACC_W'(m_sum[SUM_W-1:LEVEL_W]);
        md_req.b  = {m_sum[LEVEL_W-1:0], {(MD_SH_W - LEVEL_W){1'b0}}};
        md_req.v  = MD_DIV_W'(m_count);
        md_req.n  = MD_CNT_W'(LEVEL_W);
        md_start  = !issued && (m_count != '0);
      end
      default: ;
    endcase
  end

  gslm_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .req    (md_req),
    .busy   (md_busy),
    .done   (md_done),
    .result (md_result)
  );

  // Accumulate a kept sample in UPDATE; close the frame in REPORT.
  always_comb begin
    mctl.acc   = (state == S_UPDATE) && kept;
    mctl.close = (state == S_REPORT);
    mctl.hit   = hit_r;
    mctl.aud   = aud_now;
    mctl.mag   = mag_r;
  end

  gslm_meter #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_meter (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .sum   (m_sum),
    .peak  (m_peak),
    .count (m_count),
    .tally (m_tally),
    .seen  (m_seen),
    .full  (m_full)
  );

  // ---------------------------------------------------------------------------
  // Sequencer. Flow per word:
  //   IDLE -> [CAP1 -> CAP2] -> SC_MUL -> SC_DIV -> [LIM_MUL -> LIM_DIV]
  //        -> UPDATE -> [AVG -> REPORT] -> EMIT
  // A word past the frame cap jumps from IDLE straight to UPDATE with
  // nothing to accumulate.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (md_start) begin
        issued <= 1'b1;
      end
      if (md_done) begin
        issued <= 1'b0;
      end
      // drop the output word once taken; EMIT reloads it on its own
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg         <= in_data.in_sample[SAMPLE_W-1];
            in_mag      <= in_mag_c;
            frame_end_r <= in_data.frame_end;
            mag_r       <= '0;
            hit_r       <= 1'b0;
            if (m_full) begin
              kept  <= 1'b0;
              state <= S_UPDATE;
            end else begin
              kept  <= 1'b1;
              state <= cap_stale ? S_CAP1 : S_SC_MUL;
            end
          end
        end

        S_CAP1: begin
          if (md_done) begin
            p1    <= md_result[2*GAIN_W-1:0];
            state <= S_CAP2;
          end
        end

        S_CAP2: begin
          // use the cap ratio when num/den exceeds max_num/max_den
          if (md_done) begin
            if (p1 > md_result[2*GAIN_W-1:0]) begin
              gnum <= max_num;
              gden <= mden_eff;
            end else begin
              gnum <= ratio_num;
              gden <= den_eff;
            end
            state <= S_SC_MUL;
          end
        end

        S_SC_MUL: begin
          if (md_done) begin
            work  <= md_result;
            state <= S_SC_DIV;
          end
        end

        S_SC_DIV: begin
          if (md_done) begin
            if (out_limit == '0) begin
              // silent output, not counted as limited
              mag_r <= '0;
              hit_r <= 1'b0;
              state <= S_UPDATE;
            end else if (scaled <= MD_SH_W'(knee) || knee >= out_limit) begin
              // below the knee, or no knee: hard clamp only
              if (scaled > MD_SH_W'(out_limit)) begin
                mag_r <= out_limit;
                hit_r <= 1'b1;
              end else begin
                mag_r <= scaled[LEVEL_W-1:0];
                hit_r <= 1'b0;
              end
              state <= S_UPDATE;
            end else begin
              // soft knee: hold the overshoot above the knee
              work  <= MD_ACC_W'(scaled - MD_SH_W'(knee));
              state <= S_LIM_MUL;
            end
          end
        end

        S_LIM_MUL: begin
          if (md_done) begin
            dvs   <= MD_DIV_W'(work[MD_SH_W-1:0]) + MD_DIV_W'(knee_range);
            work  <= md_result;
            state <= S_LIM_DIV;
          end
        end

        S_LIM_DIV: begin
          if (md_done) begin
            // quotient < range, so knee + quotient stays below the limit
            mag_r <= knee + md_result[LEVEL_W-1:0];
            hit_r <= 1'b1;
            state <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          state <= frame_end_r ? S_AVG : S_EMIT;
        end

        S_AVG: begin
          if (m_count == '0) begin
            avg_r <= '0;
            state <= S_REPORT;
          end else if (md_done) begin
            avg_r <= md_result[LEVEL_W-1:0];
            state <= S_REPORT;
          end
        end

        S_REPORT: begin
          // snapshot frame stats; the meter clears on this edge
          rep_peak  <= m_peak;
          rep_tally <= m_tally;
          rep_aud   <= aud_now;
          state     <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (neg && mag_r != '0) begin
              out_data.out_sample <= SAMPLE_W'(0) - SAMPLE_W'(mag_r);
            end else begin
              out_data.out_sample <= SAMPLE_W'(mag_r);
            end
            out_data.sample_kept     <= kept;
            out_data.stats_valid     <= frame_end_r;
            out_data.average_level   <= frame_end_r ? avg_r : '0;
            out_data.peak_level      <= frame_end_r ? rep_peak : '0;
            out_data.audible         <= frame_end_r && rep_aud;
            out_data.limited_samples <= frame_end_r ? TALLY_W'(rep_tally) : '0;
            out_data.audible_ever    <= m_seen;
            state                    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall, "input not held")
  `ASSERT_IMPLY(a_md_free, clk, rst, md_start, !md_busy, "serial unit started while busy")
  `ASSERT_ALWAYS(a_count_cap, clk, rst, m_count <= CNT_W'(MAX_FRAME_SAMPLES), "count past cap")
  `ASSERT_ALWAYS(a_tally_le_count, clk, rst, m_tally <= m_count, "tally above count")

endmodule

@@ dv/gain_soft_limiter_level_meter_test.sv @@
module gain_soft_limiter_level_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gslm_pkg::*;

  // Cycles with no word moving on any channel before the run is called hung.
  // It must outlast the slowest word and the long receiver hold.
  localparam int QUIET_LIMIT  = 3000;
  // Quiet tail after the last result.
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 400;

  // Mirror of the eight gain and limiter registers.
  typedef struct packed {
    logic [GAIN_W-1:0]  ratio_num;
    logic [GAIN_W-1:0]  ratio_den;
    logic [GAIN_W-1:0]  max_num;
    logic [GAIN_W-1:0]  max_den;
    logic [LEVEL_W-1:0] knee;
    logic [LEVEL_W-1:0] limit;
    logic [LEVEL_W-1:0] avg_thresh;
    logic [LEVEL_W-1:0] peak_thresh;
  } gain_setting_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Registers and frame meter as the block should hold them.
  gain_setting_t       live_cfg;
  logic [23:0]         frame_mag_sum;
  logic [LEVEL_W-1:0]  frame_mag_peak;
  logic [TALLY_W-1:0]  frame_words;
  logic [TALLY_W-1:0]  frame_limited;
  logic                heard_any;

  // Result words predicted at input acceptance, oldest first.
  out_word_t expected_words[$];

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_req      = 0;   // bumped by a test to start a long receiver hold
  int hold_ack      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int fail_count    = 0;
  int words_seen    = 0;
  out_word_t want;

  gain_soft_limiter_level_meter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic gain_setting_t default_setting();
    gain_setting_t s;
    s.ratio_num   = GAIN_RST;
    s.ratio_den   = GAIN_RST;
    s.max_num     = GAIN_RST;
    s.max_den     = GAIN_RST;
    s.knee        = KNEE_RST;
    s.limit       = LIMIT_RST;
    s.avg_thresh  = AVG_THRESH_RST;
    s.peak_thresh = PEAK_THRESH_RST;
    return s;
  endfunction

  function automatic void clear_frame();
    frame_mag_sum  = '0;
    frame_mag_peak = '0;
    frame_words    = '0;
    frame_limited  = '0;
  endfunction

  function automatic void reset_mirror();
    live_cfg  = default_setting();
    heard_any = 1'b0;
    clear_frame();
  endfunction

  // Track a register write; the level registers keep only their low 15 bits.
  function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_GAIN_NUM:     live_cfg.ratio_num   = val;
      REG_GAIN_DEN:     live_cfg.ratio_den   = val;
      REG_MAX_GAIN_NUM: live_cfg.max_num     = val;
      REG_MAX_GAIN_DEN: live_cfg.max_den     = val;
      REG_KNEE:         live_cfg.knee        = val[LEVEL_W-1:0];
      REG_LIMIT:        live_cfg.limit       = val[LEVEL_W-1:0];
      REG_AVG_THRESH:   live_cfg.avg_thresh  = val[LEVEL_W-1:0];
      REG_PEAK_THRESH:  live_cfg.peak_thresh = val[LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  // Soft-knee limiter on a scaled magnitude; hit flags that it acted.
  function automatic logic [LEVEL_W-1:0] soft_knee_mag(input logic [63:0] mag,
                                                       output logic hit);
    logic [63:0] knee, lim, over, span, m;
    knee = 64'(live_cfg.knee);
    lim  = 64'(live_cfg.limit);
    hit  = 1'b0;
    if (lim == 0)
      return '0;
    if (mag <= knee || knee >= lim) begin
      if (mag > lim) begin
        hit = 1'b1;
        return lim[LEVEL_W-1:0];
      end
      return mag[LEVEL_W-1:0];
    end
    hit  = 1'b1;
    over = mag - knee;
    span = lim - knee;
    m    = knee + (over * span) / (over + span);
    if (m > lim)
      m = lim;
    return m[LEVEL_W-1:0];
  endfunction

  // Work out the result word for one accepted sample and advance the meter.
  function automatic out_word_t predict_level_word(input in_word_t w);
    out_word_t          r;
    logic [SAMPLE_W-1:0] raw, signed_mag;
    logic                neg, hit;
    logic [63:0]         in_mag, num, den, mnum, mden, scaled, avg;
    logic [LEVEL_W-1:0]  mag;
    r      = '0;
    raw    = w.in_sample;
    neg    = raw[SAMPLE_W-1];
    in_mag = neg ? (64'h10000 - 64'(raw)) : 64'(raw);
    if (frame_words < MAX_FRAME_SAMPLES_DEF) begin
      num  = 64'(live_cfg.ratio_num);
      den  = (live_cfg.ratio_den == 0) ? 64'd1 : 64'(live_cfg.ratio_den);
      mnum = 64'(live_cfg.max_num);
      mden = (live_cfg.max_den == 0) ? 64'd1 : 64'(live_cfg.max_den);
      // Cap the ratio; compare cross products so no division is needed.
      if (num * mden > mnum * den) begin
        num = mnum;
        den = mden;
      end
      scaled = (in_mag * num) / den;
      mag    = soft_knee_mag(scaled, hit);
      signed_mag    = {1'b0, mag};
      r.out_sample  = neg ? (~signed_mag + 1'b1) : signed_mag;
      r.sample_kept = 1'b1;
      frame_mag_sum = frame_mag_sum + 24'(mag);
      if (mag > frame_mag_peak)
        frame_mag_peak = mag;
      frame_words = frame_words + TALLY_W'(1);
      if (hit)
        frame_limited = frame_limited + TALLY_W'(1);
    end
    // A frame end closes the frame even when the word itself was dropped.
    if (w.frame_end) begin
      avg = (frame_words != 0) ? 64'(frame_mag_sum) / 64'(frame_words) : 64'd0;
      r.stats_valid     = 1'b1;
      r.average_level   = avg[LEVEL_W-1:0];
      r.peak_level      = frame_mag_peak;
      r.audible         = (avg >= 64'(live_cfg.avg_thresh)) ||
                          (frame_mag_peak >= live_cfg.peak_thresh);
      r.limited_samples = frame_limited;
      if (r.audible)
        heard_any = 1'b1;
      clear_frame();
    end
    r.audible_ever = heard_any;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one sample word, idling first at random; hold it until accepted.
  // Leave in_valid high afterwards: the next call or settle_block decides.
  task automatic send_word(input logic [SAMPLE_W-1:0] sample, input logic last);
    in_word_t w;
    w.in_sample = sample;
    w.frame_end = last;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(predict_level_word(w));
  endtask

  // Drop the input, then wait until every predicted word has come back.
  task automatic settle_block();
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    mirror_reg(idx, val);
  endtask

  // Load all eight registers while the block is idle. The level registers
  // get a random bit 15, which the block must ignore.
  task automatic apply_setting(input gain_setting_t s);
    settle_block();
    write_reg(REG_GAIN_NUM,     s.ratio_num);
    write_reg(REG_GAIN_DEN,     s.ratio_den);
    write_reg(REG_MAX_GAIN_NUM, s.max_num);
    write_reg(REG_MAX_GAIN_DEN, s.max_den);
    write_reg(REG_KNEE,         {$urandom_range(1) != 0, s.knee});
    write_reg(REG_LIMIT,        {$urandom_range(1) != 0, s.limit});
    write_reg(REG_AVG_THRESH,   {$urandom_range(1) != 0, s.avg_thresh});
    write_reg(REG_PEAK_THRESH,  {$urandom_range(1) != 0, s.peak_thresh});
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog
  // ---------------------------------------------------------------------------

  task automatic show_word(input string tag, input out_word_t w);
    $display("  %s sample %0d kept %0b stats %0b avg %0d peak %0d aud %0b lim %0d ever %0b",
             tag, w.out_sample, w.sample_kept, w.stats_valid, w.average_level,
             w.peak_level, w.audible, w.limited_samples, w.audible_ever);
  endtask

  function automatic bit same_word(input out_word_t a, input out_word_t b);
    return (a.out_sample === b.out_sample) && (a.sample_kept === b.sample_kept) &&
           (a.stats_valid === b.stats_valid) && (a.average_level === b.average_level) &&
           (a.peak_level === b.peak_level) && (a.audible === b.audible) &&
           (a.limited_samples === b.limited_samples) &&
           (a.audible_ever === b.audible_ever);
  endfunction

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("result word %0d arrived with nothing predicted", words_seen);
          show_word("got     ", out_data);
        end
      end else begin
        want = expected_words.pop_front();
        if (!same_word(want, out_data)) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("result word %0d differs", words_seen);
            show_word("expected", want);
            show_word("got     ", out_data);
          end
        end
      end
    end
  end

  // Count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no word moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mix full-range, quiet, near-knee and extreme samples.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] v;
    int                  m;
    case ($urandom_range(3))
      0: v = SAMPLE_W'($urandom_range(65535));
      1: v = SAMPLE_W'($urandom_range(2000));
      2: begin
        m = int'(live_cfg.knee) + int'($urandom_range(400)) - 200;
        if (m < 0)
          m = 0;
        if (m > 32767)
          m = 32767;
        v = SAMPLE_W'(m);
      end
      default: begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
        return v;
      end
    endcase
    return ($urandom_range(1) != 0) ? (~v + 1'b1) : v;
  endfunction

  // Gains mostly small so the limiter is not always saturated.
  function automatic gain_setting_t rand_setting();
    gain_setting_t      s;
    logic [LEVEL_W-1:0] t;
    s.ratio_num   = GAIN_W'(($urandom_range(1) != 0) ? $urandom_range(8) : $urandom_range(65535));
    s.ratio_den   = GAIN_W'(($urandom_range(1) != 0) ? $urandom_range(8) : $urandom_range(65535));
    s.max_num     = GAIN_W'(($urandom_range(1) != 0) ? $urandom_range(8) : $urandom_range(65535));
    s.max_den     = GAIN_W'(($urandom_range(1) != 0) ? $urandom_range(8) : $urandom_range(65535));
    s.knee        = LEVEL_W'($urandom_range(32767));
    s.limit       = LEVEL_W'($urandom_range(32767));
    // Keep the knee below the limit most of the time.
    if ($urandom_range(3) != 0 && s.knee > s.limit) begin
      t       = s.knee;
      s.knee  = s.limit;
      s.limit = t;
    end
    s.avg_thresh  = LEVEL_W'(($urandom_range(1) != 0) ? $urandom_range(3000)
                                                      : $urandom_range(32767));
    s.peak_thresh = LEVEL_W'(($urandom_range(1) != 0) ? $urandom_range(3000)
                                                      : $urandom_range(32767));
    return s;
  endfunction

  // Send well-formed frames of random length; now and then a noisy stretch
  // with frame-end marks at random.
  task automatic run_traffic(input int count);
    int left, len;
    bit noisy;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(16, 1);
      if (len > left)
        len = left;
      noisy = ($urandom_range(7) == 0);
      for (int i = 0; i < len; i++)
        send_word(rand_sample(), noisy ? ($urandom_range(1) != 0) : (i == len - 1));
      left -= len;
    end
  endtask

  // Registers at their reset values: a quiet frame leaves the sticky flag
  // clear, then a loud one walks across the knee and the limit.
  task automatic test_reset_defaults();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_word(16'sd0, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd100, 1'b1);
    send_word(16'sd32767, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'sd24000, 1'b0);
    send_word(-16'sd24001, 1'b0);
    send_word(16'sd30000, 1'b0);
    send_word(16'sd30001, 1'b1);
  endtask

  // Gain ratio: under the cap, over the cap, zero denominators, zero cap.
  task automatic test_gain_ratio();
    gain_setting_t s;
    s = default_setting();
    s.ratio_num = 3; s.ratio_den = 2; s.max_num = 2; s.max_den = 1;
    apply_setting(s);
    send_word(16'sd10000, 1'b0);
    send_word(-16'sd21845, 1'b1);
    s.ratio_num = 5; s.ratio_den = 1; s.max_num = 3; s.max_den = 2;
    apply_setting(s);
    send_word(16'sd20001, 1'b0);
    send_word(-16'sd3, 1'b1);
    s.ratio_num = 16'hFFFF; s.ratio_den = 0; s.max_num = 16'hFFFF; s.max_den = 0;
    apply_setting(s);
    send_word(16'h8000, 1'b0);
    send_word(16'sd1, 1'b1);
    s.ratio_num = 9; s.ratio_den = 2; s.max_num = 0; s.max_den = 5;
    apply_setting(s);
    send_word(16'sd32767, 1'b0);
    send_word(-16'sd7, 1'b1);
  endtask

  // Limiter shapes: knee above the limit, zero limit, zero knee, both at max.
  task automatic test_limiter_shape();
    gain_setting_t s;
    s = default_setting();
    s.knee = 20000; s.limit = 10000;
    apply_setting(s);
    send_word(16'sd15000, 1'b0);
    send_word(-16'sd5000, 1'b1);
    s.knee = 100; s.limit = 0;
    apply_setting(s);
    send_word(16'sd32767, 1'b0);
    send_word(-16'sd5, 1'b1);
    s.knee = 0; s.limit = 15'h7FFF;
    apply_setting(s);
    send_word(-16'sd1, 1'b0);
    send_word(16'h8000, 1'b1);
    s.knee = 15'h7FFF; s.limit = 15'h7FFF; s.avg_thresh = 15'h7FFF; s.peak_thresh = 0;
    apply_setting(s);
    send_word(16'h8000, 1'b0);
    send_word(16'sd32767, 1'b1);
  endtask

  // Random settings under each idling mix; the two extreme settings ride
  // along as the first setting of two of the phases.
  task automatic test_random_traffic();
    gain_setting_t s;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 50; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 50; end
        default: begin snd_idle_pct = 14; rcv_stall_pct = 14; end
      endcase
      for (int k = 0; k < 3; k++) begin
        s = rand_setting();
        if (phase == 1 && k == 0)
          s = '1;
        else if (phase == 2 && k == 0)
          s = '0;
        apply_setting(s);
        run_traffic(45);
      end
    end
  endtask

  // Frame cap: a frame that runs past the cap and is closed by a dropped
  // word, then a short frame to show the clear. Gain 4 pushes most samples
  // into the limiter so the tally runs high.
  task automatic test_frame_cap();
    gain_setting_t s;
    s = default_setting();
    s.ratio_num = 4; s.max_num = 4; s.knee = 20000;
    snd_idle_pct  = 14;
    rcv_stall_pct = 14;
    apply_setting(s);
    for (int i = 0; i < MAX_FRAME_SAMPLES_DEF + 4; i++)
      send_word(rand_sample(), 1'b0);
    send_word(rand_sample(), 1'b1);
    send_word(rand_sample(), 1'b0);
    send_word(rand_sample(), 1'b0);
    send_word(rand_sample(), 1'b1);
  endtask

  // Hold the receiver off while the sender keeps offering words, so the
  // block fills and stalls its input.
  task automatic test_backpressure();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req++;
    for (int i = 0; i < 24; i++)
      send_word(rand_sample(), ($urandom_range(3) == 0) || i == 23);
  endtask

  initial begin
    reset_mirror();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_gain_ratio();
    test_limiter_shape();
    test_random_traffic();
    test_frame_cap();
    test_backpressure();

    // Drain, then watch a quiet tail for stray results.
    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/gslm_pkg.sv
rtl/core/gslm_muldiv.sv
rtl/core/gslm_meter.sv
rtl/core/gain_soft_limiter_level_meter.sv
dv/gain_soft_limiter_level_meter_test.sv
